[rtl/plqm_pkg.sv]
// Shared types and constants of the peer link quality monitor.
// No dependencies; used by every module under rtl.
`timescale 1ns / 1ps

package plqm_pkg;

  localparam logic [15:0] PING_INTERVAL_RST = 16'd1000;
  localparam logic [23:0] PEER_TIMEOUT_RST  = 24'd60000;
  localparam logic [16:0] LOSS_FULL         = 17'd65536;

  typedef enum logic [2:0] {
    CMD_CONNECT    = 3'd0,
    CMD_DISCONNECT = 3'd1,
    CMD_SEEN       = 3'd2,
    CMD_PONG       = 3'd3,
    CMD_TICK       = 3'd4,
    CMD_QUERY      = 3'd5,
    CMD_PING_REQ   = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_PING    = 2'd0,
    KIND_PONG    = 2'd1,
    KIND_TIMEOUT = 2'd2,
    KIND_QUERY   = 2'd3
  } kind_e;

  localparam logic [0:0] CFG_INTERVAL = 1'b0;
  localparam logic [0:0] CFG_TIMEOUT  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PING,
    ST_TOUT,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    kind_e              kind;
    logic [3:0]         peer_slot;
    logic [31:0]        stamp_echo;
    logic [31:0]        stamp_local;
    logic [31:0]        round_trip_ms;
    logic [35:0]        jitter_q4;
    logic [16:0]        loss_q16;
    logic signed [31:0] remote_ofs_ms;
    logic               present;
    logic               last_of_run;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // latch the input item
    logic do_single;  // execute a non-tick item
    logic do_round;   // tick: take the round decision
    logic ping_step;  // one slot of the ping walk
    logic tout_step;  // one slot of the timeout walk
    logic flush;      // push the held result as last of run
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic round_hit;
    logic ping_hit;
    logic tout_hit;
    logic can_push;
    logic pend_v;
  } stat_t;

endpackage

[rtl/plqm_ctrl.sv]
// Sequencer of the peer link quality monitor: accepts items, walks the slots on a tick.
// Depends on plqm_pkg.
`timescale 1ns / 1ps

module plqm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  plqm_pkg::stat_t stat_i,
  input  logic            idx_last_i,
  output plqm_pkg::ctrl_t ctrl_o
);

  plqm_pkg::state_e state_q, state_d;
  logic ping_ok, tout_ok;

  // a hit needs room only when a held result must move on
  assign ping_ok = !(stat_i.ping_hit && stat_i.pend_v && !stat_i.can_push);
  assign tout_ok = !(stat_i.tout_hit && stat_i.pend_v && !stat_i.can_push);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plqm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      plqm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = plqm_pkg::ST_EXEC;
        end
      end
      plqm_pkg::ST_EXEC: begin
        priority if (stat_i.cmd == plqm_pkg::CMD_TICK) begin
          ctrl_o.do_round = 1'b1;
          state_d = stat_i.round_hit ? plqm_pkg::ST_PING : plqm_pkg::ST_TOUT;
        end else if (stat_i.cmd == plqm_pkg::CMD_QUERY ||
                     stat_i.cmd == plqm_pkg::CMD_PING_REQ) begin
          if (stat_i.can_push) begin
            ctrl_o.do_single = 1'b1;
            state_d = plqm_pkg::ST_IDLE;
          end
        end else begin
          ctrl_o.do_single = 1'b1;
          state_d = plqm_pkg::ST_IDLE;
        end
      end
      plqm_pkg::ST_PING: begin
        if (ping_ok) begin
          ctrl_o.ping_step = 1'b1;
          if (idx_last_i) state_d = plqm_pkg::ST_TOUT;
        end
      end
      plqm_pkg::ST_TOUT: begin
        if (tout_ok) begin
          ctrl_o.tout_step = 1'b1;
          if (idx_last_i) state_d = plqm_pkg::ST_FLUSH;
        end
      end
      plqm_pkg::ST_FLUSH: begin
        if (!stat_i.pend_v) begin
          state_d = plqm_pkg::ST_IDLE;
        end else if (stat_i.can_push) begin
          ctrl_o.flush = 1'b1;
          state_d = plqm_pkg::ST_IDLE;
        end
      end
      default: state_d = plqm_pkg::ST_IDLE;
    endcase
  end

endmodule

[rtl/plqm_dp.sv]
// Datapath of the peer link quality monitor: peer table, statistics, result registers.
// Depends on plqm_pkg; driven by plqm_ctrl.
`timescale 1ns / 1ps

module plqm_dp #(
  parameter int PEER_SLOTS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  plqm_pkg::ctrl_t ctrl_i,
  output plqm_pkg::stat_t stat_o,
  output logic            idx_last_o,
  input  logic [2:0]      in_cmd_i,
  input  logic [3:0]      in_slot_i,
  input  logic [31:0]     in_now_i,
  input  logic [31:0]     in_sent_i,
  input  logic [31:0]     in_remote_i,
  input  logic            cfg_we_i,
  input  logic [0:0]      cfg_index_i,
  input  logic [23:0]     cfg_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output plqm_pkg::res_t  out_o
);

  localparam int IW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam logic [IW-1:0] IDX_LAST = IW'(PEER_SLOTS - 1);

  function automatic logic [16:0] loss_step(input logic [16:0] l, input logic lost);
    logic [16:0] x;
    logic [17:0] xr;
    logic [33:0] p;
    logic [16:0] d;
    x  = lost ? (plqm_pkg::LOSS_FULL - l) : l;
    xr = 18'(x) + 18'd9;
    // ceil(x/10) by reciprocal, exact for x up to 2^17
    p  = 34'(xr) * 34'(16'd52429);
    d  = 17'(p >> 19);
    return lost ? (l + d) : (l - d);
  endfunction

  logic [15:0] interval_q;
  logic [23:0] timeout_q;
  logic [31:0] last_round_q;

  plqm_pkg::cmd_e cmd_q;
  logic [3:0]  slot_q;
  logic [31:0] now_q, sent_q, remote_q;

  logic [PEER_SLOTS-1:0] live_q;
  logic [31:0] heard_mem  [PEER_SLOTS];
  logic        await_mem  [PEER_SLOTS];
  logic [31:0] rtt_mem    [PEER_SLOTS];
  logic [35:0] jit_mem    [PEER_SLOTS];
  logic [16:0] loss_mem   [PEER_SLOTS];
  logic [31:0] off_mem    [PEER_SLOTS];

  logic [IW-1:0] idx_q;
  logic          pend_v_q, out_v_q;
  plqm_pkg::res_t pend_q, out_q;

  logic          slot_ok, live, rd_live, can_push;
  logic          ping_hit, tout_hit, walk_hit, single_out, out_load;
  logic [IW-1:0] slot_ix, rd_ix;
  logic [31:0]   rtt, prev, dev, offset;
  logic [39:0]   jsum;
  logic [35:0]   jnew;
  logic [31:0]   silent;
  plqm_pkg::res_t single_res, walk_res, flush_res;

  assign slot_ok = {2'b00, slot_q} < 6'(PEER_SLOTS);
  assign slot_ix = IW'(slot_q);
  assign live    = slot_ok && live_q[slot_ix];
  assign rd_ix   = (cmd_q == plqm_pkg::CMD_TICK) ? idx_q : slot_ix;
  assign rd_live = live_q[rd_ix];

  assign rtt    = now_q - sent_q;
  assign prev   = rtt_mem[rd_ix];
  assign dev    = (rtt >= prev) ? (rtt - prev) : (prev - rtt);
  assign jsum   = {1'b0, jit_mem[rd_ix], 3'b000} - 40'(jit_mem[rd_ix]) +
                  {4'b0000, dev, 4'b0000};
  assign jnew   = jsum[38:3];
  assign offset = remote_q + (rtt >> 1) - now_q;
  assign silent = now_q - heard_mem[rd_ix];

  assign can_push = !out_v_q || out_ready_i;

  // hit flags for the controller, independent of whether the step is issued
  assign ping_hit = rd_live;
  assign tout_hit = rd_live && (silent > 32'(timeout_q));
  assign walk_hit = (ctrl_i.ping_step && ping_hit) || (ctrl_i.tout_step && tout_hit);

  assign single_out = ctrl_i.do_single &&
                      (cmd_q == plqm_pkg::CMD_QUERY || cmd_q == plqm_pkg::CMD_PING_REQ);
  assign out_load   = single_out || (walk_hit && pend_v_q) || ctrl_i.flush;

  always_comb begin
    single_res = '0;
    single_res.peer_slot   = slot_q;
    single_res.last_of_run = 1'b1;
    if (cmd_q == plqm_pkg::CMD_QUERY) begin
      single_res.kind = plqm_pkg::KIND_QUERY;
      if (live) begin
        single_res.round_trip_ms = rtt_mem[rd_ix];
        single_res.jitter_q4     = jit_mem[rd_ix];
        single_res.loss_q16      = loss_mem[rd_ix];
        single_res.remote_ofs_ms = off_mem[rd_ix];
        single_res.present       = 1'b1;
      end
    end else begin
      single_res.kind        = plqm_pkg::KIND_PONG;
      single_res.stamp_echo  = sent_q;
      single_res.stamp_local = now_q;
    end
    walk_res = '0;
    walk_res.peer_slot = 4'(idx_q);
    if (ctrl_i.tout_step) begin
      walk_res.kind = plqm_pkg::KIND_TIMEOUT;
    end else begin
      walk_res.kind       = plqm_pkg::KIND_PING;
      walk_res.stamp_echo = now_q;
    end
    flush_res = pend_q;
    flush_res.last_of_run = 1'b1;
  end

  assign stat_o.cmd       = cmd_q;
  assign stat_o.round_hit = (now_q - last_round_q) >= 32'(interval_q);
  assign stat_o.ping_hit  = ping_hit;
  assign stat_o.tout_hit  = tout_hit;
  assign stat_o.can_push  = can_push;
  assign stat_o.pend_v    = pend_v_q;
  assign idx_last_o       = (idx_q == IDX_LAST);

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q   <= plqm_pkg::PING_INTERVAL_RST;
      timeout_q    <= plqm_pkg::PEER_TIMEOUT_RST;
      last_round_q <= '0;
      cmd_q        <= plqm_pkg::CMD_CONNECT;
      live_q       <= '0;
      idx_q        <= '0;
      pend_v_q     <= 1'b0;
      out_v_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          plqm_pkg::CFG_INTERVAL: interval_q <= cfg_data_i[15:0];
          plqm_pkg::CFG_TIMEOUT:  timeout_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (ctrl_i.load) cmd_q <= plqm_pkg::cmd_e'(in_cmd_i);
      out_v_q <= out_load || (out_v_q && !out_ready_i);
      if (ctrl_i.do_round) begin
        idx_q <= '0;
        if (stat_o.round_hit) last_round_q <= now_q;
      end
      if (ctrl_i.do_single) begin
        unique case (cmd_q)
          plqm_pkg::CMD_CONNECT:    if (slot_ok) live_q[slot_ix] <= 1'b1;
          plqm_pkg::CMD_DISCONNECT: if (slot_ok) live_q[slot_ix] <= 1'b0;
          default: ;
        endcase
      end
      if (ctrl_i.ping_step || ctrl_i.tout_step) begin
        idx_q <= (idx_q == IDX_LAST) ? '0 : idx_q + IW'(1);
        if (walk_hit) pend_v_q <= 1'b1;
        if (ctrl_i.tout_step && tout_hit) live_q[idx_q] <= 1'b0;
      end
      if (ctrl_i.flush) pend_v_q <= 1'b0;
    end
  end

  // payload and table contents
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      slot_q   <= in_slot_i;
      now_q    <= in_now_i;
      sent_q   <= in_sent_i;
      remote_q <= in_remote_i;
    end
    if (ctrl_i.do_single) begin
      unique case (cmd_q)
        plqm_pkg::CMD_CONNECT: if (slot_ok) begin
          heard_mem[slot_ix] <= now_q;
          await_mem[slot_ix] <= 1'b0;
          rtt_mem[slot_ix]   <= '0;
          jit_mem[slot_ix]   <= '0;
          loss_mem[slot_ix]  <= '0;
          off_mem[slot_ix]   <= '0;
        end
        plqm_pkg::CMD_SEEN: if (live) heard_mem[slot_ix] <= now_q;
        plqm_pkg::CMD_PONG: if (live) begin
          heard_mem[slot_ix] <= now_q;
          jit_mem[slot_ix]   <= jnew;
          rtt_mem[slot_ix]   <= rtt;
          off_mem[slot_ix]   <= offset;
          await_mem[slot_ix] <= 1'b0;
        end
        plqm_pkg::CMD_QUERY: out_q <= single_res;
        plqm_pkg::CMD_PING_REQ: begin
          if (live) heard_mem[slot_ix] <= now_q;
          out_q <= single_res;
        end
        default: ;
      endcase
    end
    if (ctrl_i.ping_step && ping_hit) begin
      loss_mem[idx_q]  <= loss_step(loss_mem[idx_q], await_mem[idx_q]);
      await_mem[idx_q] <= 1'b1;
    end
    if (walk_hit) begin
      pend_q <= walk_res;
      if (pend_v_q) out_q <= pend_q;
    end
    if (ctrl_i.flush) out_q <= flush_res;
  end

endmodule

[rtl/peer_link_quality_monitor_top.sv]
// Top level of the peer link quality monitor: stream ports, config port, ctrl + datapath.
// Depends on plqm_pkg, plqm_ctrl, plqm_dp.
//
//   channel   direction  handshake                     payload
//   s_axis    in         s_axis_tvalid/tready          tuser command, tdata item fields
//   m_axis    out        m_axis_tvalid/tready          tuser kind, tdata result, tlast
//   cfg       in         cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// Non-tick items pass through accept and execute, and wait in execute for the output
// register when they give a result. A tick is accepted, takes the round decision, walks
// the slots for pings when a ping round starts, then for timeouts, then flushes any held
// result: the slot walk reads one peer slot per cycle, and stalls when a new hit must
// move the held result on while the output register is full. One item is worked on at a
// time; the next is accepted while the last result still waits. Reset is asynchronous
// and clears the live flags.
`timescale 1ns / 1ps

module peer_link_quality_monitor_top #(
  parameter int PEER_SLOTS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // slot[3:0] now_ms[35:4] sent_stamp[67:36]
                                      // remote_stamp[99:68], zero pad
  input  logic [2:0]   s_axis_tuser,  // command
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [191:0] m_axis_tdata,  // peer_slot[3:0] stamp_echo[35:4] stamp_local[67:36]
                                      // round_trip_ms[99:68] jitter_q4[135:100]
                                      // loss_q16[152:136] remote offset[184:153]
                                      // present[185], zero pad
  output logic [1:0]   m_axis_tuser,  // kind
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [0:0]   cfg_index_i,
  input  logic [23:0]  cfg_data_i
);

  plqm_pkg::ctrl_t ctrl;
  plqm_pkg::stat_t stat;
  plqm_pkg::res_t  res;
  logic idx_last;

  assign cfg_ready_o = 1'b1;

  plqm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .idx_last_i (idx_last),
    .ctrl_o     (ctrl)
  );

  plqm_dp #(.PEER_SLOTS(PEER_SLOTS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .idx_last_o  (idx_last),
    .in_cmd_i    (s_axis_tuser),
    .in_slot_i   (s_axis_tdata[3:0]),
    .in_now_i    (s_axis_tdata[35:4]),
    .in_sent_i   (s_axis_tdata[67:36]),
    .in_remote_i (s_axis_tdata[99:68]),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last_of_run;
  assign m_axis_tdata = {6'b000000, res.present, res.remote_ofs_ms, res.loss_q16,
                         res.jitter_q4, res.round_trip_ms, res.stamp_local,
                         res.stamp_echo, res.peer_slot};

endmodule

[rtl/plqm_checker.sv]
// Port-level checks of the peer link quality monitor, bound to the top level.
// Depends on plqm_pkg and peer_link_quality_monitor_top.
`timescale 1ns / 1ps

module plqm_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [191:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser,
  input logic         m_axis_tlast
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == plqm_pkg::KIND_PONG ||
                      m_axis_tuser == plqm_pkg::KIND_QUERY) |-> m_axis_tlast)
    else $error("pong or query answer not last of run");

  a_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != plqm_pkg::KIND_QUERY |-> !m_axis_tdata[185])
    else $error("present set outside a query answer");

  a_ping_local: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == plqm_pkg::KIND_PING |-> m_axis_tdata[67:36] == 32'd0)
    else $error("ping request with local stamp");

endmodule

bind peer_link_quality_monitor_top plqm_checker u_plqm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

[sim/tb_peer_link_quality_monitor_top.sv]
// Self-checking bench for peer_link_quality_monitor_top: peer table, ping rounds,
// pong statistics, timeouts and queries against a built-in predictor.
// Depends on rtl/plqm_pkg.sv and rtl/peer_link_quality_monitor_top.sv.
`timescale 1ns / 1ps

class link_stats_board;
  logic [15:0] interval;
  logic [23:0] silence_max;
  logic        live [16];
  logic [31:0] heard [16];
  logic        waiting [16];
  logic [31:0] rtt [16];
  logic [35:0] jit [16];
  logic [16:0] loss [16];
  logic [31:0] ofs [16];
  logic [31:0] last_round;
  plqm_pkg::res_t due_q[$];
  plqm_pkg::res_t run_q[$];
  int          errors;
  int          results;

  function new();
    interval    = plqm_pkg::PING_INTERVAL_RST;
    silence_max = plqm_pkg::PEER_TIMEOUT_RST;
    foreach (live[i]) live[i] = 1'b0;
    last_round = '0;
    errors     = 0;
    results    = 0;
  endfunction

  function void write_reg(logic [0:0] idx, logic [23:0] val);
    if (idx == plqm_pkg::CFG_INTERVAL) interval = val[15:0];
    else silence_max = val;
  endfunction

  function void add_result(plqm_pkg::kind_e k, logic [3:0] s, logic [31:0] echo,
                           logic [31:0] loc_stamp);
    plqm_pkg::res_t r;
    r = '0;
    r.kind        = k;
    r.peer_slot   = s;
    r.stamp_echo  = echo;
    r.stamp_local = loc_stamp;
    run_q = {run_q, r};
  endfunction

  // loss EWMA: move a tenth of the way to the target, rounded up
  function logic [16:0] loss_next(logic [16:0] l, logic lost);
    int unsigned d;
    if (lost) begin
      d = (int'(plqm_pkg::LOSS_FULL) - l + 9) / 10;
      return l + 17'(d);
    end
    d = (l + 9) / 10;
    return l - 17'(d);
  endfunction

  function void note_item(logic [2:0] cmd, logic [3:0] s, logic [31:0] now,
                          logic [31:0] sent, logic [31:0] remote);
    logic [31:0] trip;
    logic [31:0] dev;
    logic [63:0] jsum;
    plqm_pkg::res_t r;
    run_q.delete();
    case (cmd)
      plqm_pkg::CMD_CONNECT: begin
        live[s] = 1'b1; heard[s] = now; waiting[s] = 1'b0;
        rtt[s] = '0; jit[s] = '0; loss[s] = '0; ofs[s] = '0;
      end
      plqm_pkg::CMD_DISCONNECT: live[s] = 1'b0;
      plqm_pkg::CMD_SEEN: if (live[s]) heard[s] = now;
      plqm_pkg::CMD_PONG: if (live[s]) begin
        trip = now - sent;
        dev  = (trip >= rtt[s]) ? trip - rtt[s] : rtt[s] - trip;
        jsum = 64'(jit[s]) * 7 + 64'(dev) * 16;
        jit[s]     = jsum[38:3];
        heard[s]   = now;
        rtt[s]     = trip;
        ofs[s]     = remote + (trip >> 1) - now;
        waiting[s] = 1'b0;
      end
      plqm_pkg::CMD_TICK: begin
        if (now - last_round >= {16'd0, interval}) begin
          last_round = now;
          for (int i = 0; i < 16; i++) begin
            if (live[i]) begin
              loss[i]    = loss_next(loss[i], waiting[i]);
              waiting[i] = 1'b1;
              add_result(plqm_pkg::KIND_PING, 4'(i), now, '0);
            end
          end
        end
        for (int i = 0; i < 16; i++) begin
          if (live[i] && (now - heard[i]) > {8'd0, silence_max}) begin
            live[i] = 1'b0;
            add_result(plqm_pkg::KIND_TIMEOUT, 4'(i), '0, '0);
          end
        end
      end
      plqm_pkg::CMD_QUERY: begin
        r = '0;
        r.kind      = plqm_pkg::KIND_QUERY;
        r.peer_slot = s;
        if (live[s]) begin
          r.round_trip_ms = rtt[s];
          r.jitter_q4     = jit[s];
          r.loss_q16      = loss[s];
          r.remote_ofs_ms = ofs[s];
          r.present       = 1'b1;
        end
        run_q = {run_q, r};
      end
      plqm_pkg::CMD_PING_REQ: begin
        if (live[s]) heard[s] = now;
        add_result(plqm_pkg::KIND_PONG, s, sent, now);
      end
      default: ;
    endcase
    if (run_q.size() > 0) run_q[run_q.size() - 1].last_of_run = 1'b1;
    foreach (run_q[i]) due_q = {due_q, run_q[i]};
  endfunction

  function void cmp(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, e, a);
      errors++;
    end
  endfunction

  function void check_result(plqm_pkg::res_t got);
    plqm_pkg::res_t e;
    results++;
    if (due_q.size() == 0) begin
      $display("%0t unexpected result: expected none actual %0h", $time, got);
      errors++;
      return;
    end
    e = due_q.pop_front();
    cmp("kind", e.kind, got.kind);
    cmp("peer_slot", e.peer_slot, got.peer_slot);
    cmp("stamp_echo", e.stamp_echo, got.stamp_echo);
    cmp("stamp_local", e.stamp_local, got.stamp_local);
    cmp("round_trip_ms", e.round_trip_ms, got.round_trip_ms);
    cmp("jitter_q4", e.jitter_q4, got.jitter_q4);
    cmp("loss_q16", e.loss_q16, got.loss_q16);
    cmp("remote_ofs_ms", e.remote_ofs_ms, got.remote_ofs_ms);
    cmp("present", e.present, got.present);
    cmp("last_of_run", e.last_of_run, got.last_of_run);
  endfunction
endclass

module tb_peer_link_quality_monitor_top;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 60;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata;
  logic [2:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [191:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [0:0]   cfg_index_i;
  logic [23:0]  cfg_data_i;

  link_stats_board board;
  int          send_idle;
  int          sink_idle;
  int          cycles;
  int          items;
  int          ticks;
  logic [31:0] clock_ms;

  peer_link_quality_monitor_top uut (.*);

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: sample transfer on the edge, then pick the next ready
  always @(posedge clk_i) begin
    plqm_pkg::res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind          = plqm_pkg::kind_e'(m_axis_tuser);
      got.peer_slot     = m_axis_tdata[3:0];
      got.stamp_echo    = m_axis_tdata[35:4];
      got.stamp_local   = m_axis_tdata[67:36];
      got.round_trip_ms = m_axis_tdata[99:68];
      got.jitter_q4     = m_axis_tdata[135:100];
      got.loss_q16      = m_axis_tdata[152:136];
      got.remote_ofs_ms = m_axis_tdata[184:153];
      got.present       = m_axis_tdata[185];
      got.last_of_run   = m_axis_tlast;
      board.check_result(got);
    end
    m_axis_tready <= ($urandom_range(99) >= sink_idle);
  end

  task automatic send_item(logic [2:0] cmd, logic [3:0] s, logic [31:0] now,
                           logic [31:0] sent, logic [31:0] remote);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'd0, remote, sent, now, s};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_item(cmd, s, now, sent, remote);
    items++;
    if (cmd == plqm_pkg::CMD_TICK) ticks++;
  endtask

  // registers change only with the block idle
  task automatic write_reg(logic [0:0] idx, logic [23:0] val);
    s_axis_tvalid <= 1'b0;
    while (board.due_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    board.write_reg(idx, val);
  endtask

  task automatic random_items(int count);
    int          pick;
    logic [2:0]  cmd;
    logic [31:0] sent;
    for (int n = 0; n < count; n++) begin
      clock_ms = ($urandom_range(99) < 4) ? $urandom : clock_ms + $urandom_range(0, 400);
      pick = $urandom_range(99);
      if (pick < 12)      cmd = plqm_pkg::CMD_CONNECT;
      else if (pick < 17) cmd = plqm_pkg::CMD_DISCONNECT;
      else if (pick < 27) cmd = plqm_pkg::CMD_SEEN;
      else if (pick < 47) cmd = plqm_pkg::CMD_PONG;
      else if (pick < 67) cmd = plqm_pkg::CMD_TICK;
      else if (pick < 81) cmd = plqm_pkg::CMD_QUERY;
      else if (pick < 95) cmd = plqm_pkg::CMD_PING_REQ;
      else                cmd = 3'd7;
      sent = $urandom;
      if (cmd == plqm_pkg::CMD_PONG && $urandom_range(9) != 0)
        sent = clock_ms - $urandom_range(0, 500);
      send_item(cmd, 4'($urandom_range(15)), clock_ms, sent, $urandom);
    end
  endtask

  initial begin
    board = new();
    items = 0; ticks = 0;
    send_idle = 11; sink_idle = 49;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= plqm_pkg::CMD_CONNECT;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= plqm_pkg::CFG_INTERVAL;
    cfg_data_i    <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part under reset register values
    send_item(plqm_pkg::CMD_QUERY, 4'd3, 32'd5, '0, '0);
    send_item(3'd7, 4'd1, 32'd6, '1, '1);
    send_item(plqm_pkg::CMD_CONNECT, 4'd0, 32'd10, '0, '0);
    send_item(plqm_pkg::CMD_CONNECT, 4'd15, 32'd12, '0, '0);
    send_item(plqm_pkg::CMD_PING_REQ, 4'd0, 32'd20, 32'hFFFF_FFFF, '0);
    send_item(plqm_pkg::CMD_PING_REQ, 4'd5, 32'hFFFF_FFFF, 32'h1234_5678, '0);
    send_item(plqm_pkg::CMD_SEEN, 4'd0, 32'd30, '0, '0);
    send_item(plqm_pkg::CMD_PONG, 4'd7, 32'd40, 32'd1, 32'd9);
    send_item(plqm_pkg::CMD_TICK, 4'd9, 32'd1000, '0, '0);
    send_item(plqm_pkg::CMD_PONG, 4'd0, 32'd1100, 32'd1000, 32'hFFFF_FFFF);
    send_item(plqm_pkg::CMD_QUERY, 4'd0, 32'd1101, '0, '0);
    send_item(plqm_pkg::CMD_TICK, 4'd0, 32'd1500, '0, '0);
    send_item(plqm_pkg::CMD_PONG, 4'd15, 32'd1600, 32'd1000, 32'd0);
    send_item(plqm_pkg::CMD_TICK, 4'd0, 32'd2000, '0, '0);
    send_item(plqm_pkg::CMD_QUERY, 4'd15, 32'd2001, '0, '0);
    send_item(plqm_pkg::CMD_QUERY, 4'd0, 32'd2002, '0, '0);
    send_item(plqm_pkg::CMD_PONG, 4'd0, 32'd2100, 32'd2000, 32'h8000_0000);
    send_item(plqm_pkg::CMD_QUERY, 4'd0, 32'd2101, '0, '0);
    send_item(plqm_pkg::CMD_CONNECT, 4'd0, 32'd2200, '0, '0);
    send_item(plqm_pkg::CMD_QUERY, 4'd0, 32'd2201, '0, '0);
    send_item(plqm_pkg::CMD_DISCONNECT, 4'd15, 32'd2300, '0, '0);
    send_item(plqm_pkg::CMD_QUERY, 4'd15, 32'd2301, '0, '0);
    send_item(plqm_pkg::CMD_TICK, 4'd0, 32'd70000, '0, '0);
    clock_ms = 32'd70000;

    // zero registers: ping every tick, any silence times out
    write_reg(plqm_pkg::CFG_INTERVAL, 24'd0);
    write_reg(plqm_pkg::CFG_TIMEOUT, 24'd0);
    random_items(50);
    write_reg(plqm_pkg::CFG_INTERVAL, 24'd150);
    write_reg(plqm_pkg::CFG_TIMEOUT, 24'd2500);
    random_items(62);
    send_idle = 49; sink_idle = 11;
    write_reg(plqm_pkg::CFG_INTERVAL, 24'hFFFFFF);
    write_reg(plqm_pkg::CFG_TIMEOUT, 24'hFFFFFF);
    random_items(62);
    send_idle = 0; sink_idle = 0;
    write_reg(plqm_pkg::CFG_INTERVAL, 24'd300);
    write_reg(plqm_pkg::CFG_TIMEOUT, 24'd5000);
    random_items(62);
    write_reg(plqm_pkg::CFG_INTERVAL, 24'd1);
    write_reg(plqm_pkg::CFG_TIMEOUT, 24'd1);
    random_items(20);

    s_axis_tvalid <= 1'b0;
    while (board.due_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d items sent (%0d ticks), %0d results checked, %0d mismatches",
             items, ticks, board.results, board.errors);
    $display("register settings covered zero, small, mid and full-scale values");
    if (board.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
